// ===== hw/rtl/srs_pkg.sv =====
// shared types, packet codes and classification for the sensor running statistics block
package srs_pkg;

    localparam logic [7:0] TYPE_CO2   = 8'hB2;
    localparam logic [7:0] TYPE_TEMP  = 8'hB3;
    localparam logic [7:0] TYPE_HUM   = 8'hB4;
    localparam logic [7:0] TYPE_TVOC  = 8'hB5;

    localparam logic [1:0] CH_TEMP = 2'd0;
    localparam logic [1:0] CH_HUM  = 2'd1;
    localparam logic [1:0] CH_CO2  = 2'd2;
    localparam logic [1:0] CH_TVOC = 2'd3;

    localparam logic [8:0] MIN_LENGTH = 9'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic        known;
        logic [1:0]  channel;
    } t_class;

    typedef struct packed {
        logic        hit;
        logic [1:0]  channel;
        logic [31:0] sample;
    } t_cmd;

    function automatic t_class class_of(input logic [7:0] ptype);
        t_class c;
        c.known   = 1'b1;
        c.channel = CH_TEMP;
        case (ptype)
            TYPE_TEMP: c.channel = CH_TEMP;
            TYPE_HUM:  c.channel = CH_HUM;
            TYPE_CO2:  c.channel = CH_CO2;
            TYPE_TVOC: c.channel = CH_TVOC;
            default:   c.known   = 1'b0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/srs_front.sv =====
// front end: takes packets, classifies them and pushes commands into the queue
module srs_front #(
    parameter int CHANNELS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_packet_type,
    input  logic [8:0]    i_packet_length,
    input  logic [31:0]   i_sample_value,
    output logic          o_push,
    output srs_pkg::t_cmd o_cmd,
    input  logic          i_full
);

    logic          r_valid;
    srs_pkg::t_cmd r_cmd;
    srs_pkg::t_cmd n_cmd;
    srs_pkg::t_class cls;
    logic          take;

    always_comb begin
        cls        = srs_pkg::class_of(i_packet_type);
        n_cmd.hit  = cls.known && (int'(cls.channel) < CHANNELS)
                     && (i_packet_length >= srs_pkg::MIN_LENGTH);
        n_cmd.channel = n_cmd.hit ? cls.channel : 2'd0;
        n_cmd.sample  = n_cmd.hit ? i_sample_value : 32'd0;
    end

    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign take    = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== hw/rtl/srs_queue.sv =====
// short command queue between the front end and the statistics engine
module srs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srs_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output srs_pkg::t_cmd o_cmd
);

    srs_pkg::t_cmd r_mem [srs_pkg::QUEUE_DEPTH];
    logic [srs_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [srs_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [srs_pkg::QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == srs_pkg::QUEUE_CNT_W'(srs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/srs_back.sv =====
// statistics engine: channel state update, bit-serial mean divider and result register
module srs_back #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  srs_pkg::t_cmd         i_q_cmd,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_accepted,
    output logic [1:0]            o_channel,
    output logic [31:0]           o_echo_value,
    output logic [31:0]           o_mean_value,
    output logic [31:0]           o_lowest_value,
    output logic [31:0]           o_highest_value,
    output logic [COUNT_BITS-1:0] o_sample_count
);

    localparam int SUM_W     = 32 + COUNT_BITS;
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    logic [SUM_W-1:0]      r_sum [CHANNELS];
    logic [COUNT_BITS-1:0] r_cnt [CHANNELS];
    logic [31:0]           r_min [CHANNELS];
    logic [31:0]           r_max [CHANNELS];

    t_state                r_state, n_state;
    srs_pkg::t_cmd         r_cmd;
    logic                  r_neg;
    logic [COUNT_BITS-1:0] r_div;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [SUM_W-1:0]      r_quo, n_quo;
    logic [DIV_CNT_W-1:0]  r_steps;
    logic                  r_out_valid;

    logic [IDX_W-1:0]      head_idx, cur_idx;
    logic [COUNT_BITS-1:0] head_cnt, n_cnt;
    logic [SUM_W-1:0]      n_sum, cur_sum, mag;
    logic [31:0]           head_min, head_max, n_min, n_max, sample, mean;
    logic                  first;
    logic [COUNT_BITS:0]   trial, diff;
    logic                  out_free;

    assign head_idx = IDX_W'(i_q_cmd.channel);
    assign cur_idx  = IDX_W'(r_cmd.channel);
    assign out_free = !r_out_valid || !i_stall;
    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign o_valid  = r_out_valid;

    always_comb begin
        sample   = i_q_cmd.sample;
        head_cnt = r_cnt[head_idx];
        head_min = r_min[head_idx];
        head_max = r_max[head_idx];
        first    = (head_cnt == '0);
        n_min    = (first || ($signed(sample) < $signed(head_min))) ? sample : head_min;
        n_max    = (first || ($signed(sample) > $signed(head_max))) ? sample : head_max;
        if (head_cnt == '1) begin
            n_cnt = head_cnt;
            n_sum = r_sum[head_idx];
        end else begin
            n_cnt = head_cnt + 1'b1;
            n_sum = r_sum[head_idx] + {{COUNT_BITS{sample[31]}}, sample};
        end

        cur_sum = r_sum[cur_idx];
        mag     = cur_sum[SUM_W-1] ? (~cur_sum + 1'b1) : cur_sum;

        // restoring division, one quotient bit per cycle
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[COUNT_BITS-1:0];
            n_quo = {r_quo[SUM_W-2:0], 1'b1};
        end else begin
            n_rem = trial[COUNT_BITS-1:0];
            n_quo = {r_quo[SUM_W-2:0], 1'b0};
        end

        mean = r_neg ? (~r_quo[31:0] + 1'b1) : r_quo[31:0];

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_cmd.hit ? S_LOAD : S_DONE;
                end
            end
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (r_steps == DIV_CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop && i_q_cmd.hit) begin
                r_sum[head_idx] <= n_sum;
                r_cnt[head_idx] <= n_cnt;
            end
        end

        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            if (i_q_cmd.hit) begin
                r_min[head_idx] <= n_min;
                r_max[head_idx] <= n_max;
            end
        end

        case (r_state)
            S_LOAD: begin
                r_neg   <= cur_sum[SUM_W-1];
                r_div   <= r_cnt[cur_idx];
                r_rem   <= '0;
                r_quo   <= mag;
                r_steps <= DIV_CNT_W'(SUM_W);
            end
            S_DIV: begin
                r_rem   <= n_rem;
                r_quo   <= n_quo;
                r_steps <= r_steps - 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    o_accepted <= r_cmd.hit;
                    if (r_cmd.hit) begin
                        o_channel       <= r_cmd.channel;
                        o_echo_value    <= r_cmd.sample;
                        o_mean_value    <= mean;
                        o_lowest_value  <= r_min[cur_idx];
                        o_highest_value <= r_max[cur_idx];
                        o_sample_count  <= r_cnt[cur_idx];
                    end else begin
                        o_channel       <= 2'd0;
                        o_echo_value    <= 32'd0;
                        o_mean_value    <= 32'd0;
                        o_lowest_value  <= 32'd0;
                        o_highest_value <= 32'd0;
                        o_sample_count  <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/sensor_running_statistics.sv =====
// top level of the sensor running statistics block
// Keeps a running sum, sample count, minimum and maximum for up to CHANNELS sensor
// channels (temp, humidity, co2, tvoc) and returns one result transaction for every
// packet transaction, in order. A recognized packet of at least five bytes updates its
// channel and reports the sample, the mean (sum over count, truncated toward zero), the
// minimum, the maximum and the count; anything else returns a result with accepted low
// and all fields zero. The mean of an updating packet comes from the bit-serial mean
// divider, which produces one quotient bit per cycle; an ignored packet skips the
// divider. A two-entry queue between the packet front end and the statistics engine
// lets new packets be taken while a mean is being computed or a result waits for the
// output stall to drop. Statistics run from reset.
module sensor_running_statistics #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_packet_type,
    input  logic [8:0]            i_packet_length,
    input  logic signed [31:0]    i_sample_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_accepted,
    output logic [1:0]            o_channel,
    output logic signed [31:0]    o_echo_value,
    output logic signed [31:0]    o_mean_value,
    output logic signed [31:0]    o_lowest_value,
    output logic signed [31:0]    o_highest_value,
    output logic [COUNT_BITS-1:0] o_sample_count
);

    logic          q_push, q_full, q_pop, q_empty;
    srs_pkg::t_cmd push_cmd, head_cmd;

    srs_front #(
        .CHANNELS(CHANNELS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_packet_type  (i_packet_type),
        .i_packet_length(i_packet_length),
        .i_sample_value (i_sample_value),
        .o_push         (q_push),
        .o_cmd          (push_cmd),
        .i_full         (q_full)
    );

    srs_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_cmd  (head_cmd)
    );

    srs_back #(
        .CHANNELS  (CHANNELS),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_cmd        (head_cmd),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_accepted     (o_accepted),
        .o_channel      (o_channel),
        .o_echo_value   (o_echo_value),
        .o_mean_value   (o_mean_value),
        .o_lowest_value (o_lowest_value),
        .o_highest_value(o_highest_value),
        .o_sample_count (o_sample_count)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

    a_mean_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |->
            (o_lowest_value <= o_mean_value) && (o_mean_value <= o_highest_value)
            && (o_sample_count != '0))
        else $error("mean outside the channel range or count zero");

    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |->
            (o_sample_count == '0) && (o_mean_value == 32'sd0) && (o_channel == 2'd0))
        else $error("ignored packet result carries data");

endmodule

// ===== tb/srs_checker.sv =====
`timescale 1ns / 100ps
// checker for the sensor running statistics block: per-channel statistics predictor and result compare
module srs_checker #(
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [7:0]            i_packet_type,
    input  logic [8:0]            i_packet_length,
    input  logic signed [31:0]    i_sample_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_accepted,
    input  logic [1:0]            i_channel,
    input  logic signed [31:0]    i_echo_value,
    input  logic signed [31:0]    i_mean_value,
    input  logic signed [31:0]    i_lowest_value,
    input  logic signed [31:0]    i_highest_value,
    input  logic [COUNT_BITS-1:0] i_sample_count,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

    typedef struct packed {
        logic                  accepted;
        logic [1:0]            channel;
        logic [31:0]           echo;
        logic [31:0]           mean;
        logic [31:0]           lowest;
        logic [31:0]           highest;
        logic [COUNT_BITS-1:0] count;
    } t_stats_result;

    longint                  chan_sum   [4];
    logic [COUNT_BITS-1:0]   chan_count [4];
    logic signed [31:0]      chan_low   [4];
    logic signed [31:0]      chan_high  [4];
    t_stats_result           expected_stats[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_stats_result apply_packet(input logic [7:0] ptype,
                                                   input logic [8:0] plen,
                                                   input logic signed [31:0] sample);
        t_stats_result r;
        logic [1:0]    ch;
        logic          known;
        longint        avg;
        r     = '0;
        known = 1'b1;
        ch    = srs_pkg::CH_TEMP;
        case (ptype)
            srs_pkg::TYPE_TEMP: ch = srs_pkg::CH_TEMP;
            srs_pkg::TYPE_HUM:  ch = srs_pkg::CH_HUM;
            srs_pkg::TYPE_CO2:  ch = srs_pkg::CH_CO2;
            srs_pkg::TYPE_TVOC: ch = srs_pkg::CH_TVOC;
            default:            known = 1'b0;
        endcase
        if (!known || plen < srs_pkg::MIN_LENGTH)
            return r;
        if (chan_count[ch] == '0) begin
            chan_low[ch]  = sample;
            chan_high[ch] = sample;
        end else begin
            if (sample < chan_low[ch])
                chan_low[ch] = sample;
            if (sample > chan_high[ch])
                chan_high[ch] = sample;
        end
        // saturated count holds both sum and count
        if (chan_count[ch] != COUNT_FULL) begin
            chan_count[ch] = chan_count[ch] + 1'b1;
            chan_sum[ch]   = chan_sum[ch] + longint'(sample);
        end
        avg        = chan_sum[ch] / longint'(chan_count[ch]);
        r.accepted = 1'b1;
        r.channel  = ch;
        r.echo     = sample;
        r.mean     = avg[31:0];
        r.lowest   = chan_low[ch];
        r.highest  = chan_high[ch];
        r.count    = chan_count[ch];
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stats_result want;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                chan_sum[k]   = 0;
                chan_count[k] = '0;
                chan_low[k]   = '0;
                chan_high[k]  = '0;
            end
            expected_stats.delete();
        end else begin
            // result side first so a fresh packet never masks an unexpected result
            if (i_out_valid && !i_out_stall) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result transaction, expected none, actual %h",
                             $time, {i_accepted, i_channel, i_echo_value});
                    o_fail_count++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(i_accepted));
                    check_field("channel", 32'(want.channel), 32'(i_channel));
                    check_field("echo_value", want.echo, i_echo_value);
                    check_field("mean_value", want.mean, i_mean_value);
                    check_field("lowest_value", want.lowest, i_lowest_value);
                    check_field("highest_value", want.highest, i_highest_value);
                    check_field("sample_count", 32'(want.count), 32'(i_sample_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_stats.push_back(apply_packet(i_packet_type, i_packet_length,
                                                      i_sample_value));
        end
        o_pending = expected_stats.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the sensor running statistics block: clock, reset, packet stimulus and verdict
module tb;

    localparam int COUNT_BITS = 24;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_packet_type;
    logic [8:0]            i_packet_length;
    logic signed [31:0]    i_sample_value;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_accepted;
    logic [1:0]            o_channel;
    logic signed [31:0]    o_echo_value;
    logic signed [31:0]    o_mean_value;
    logic signed [31:0]    o_lowest_value;
    logic signed [31:0]    o_highest_value;
    logic [COUNT_BITS-1:0] o_sample_count;

    int fail_count;
    int pending;
    int gap_pct;
    int stall_pct;

    sensor_running_statistics #(
        .CHANNELS   (4),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_packet_type   (i_packet_type),
        .i_packet_length (i_packet_length),
        .i_sample_value  (i_sample_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_accepted      (o_accepted),
        .o_channel       (o_channel),
        .o_echo_value    (o_echo_value),
        .o_mean_value    (o_mean_value),
        .o_lowest_value  (o_lowest_value),
        .o_highest_value (o_highest_value),
        .o_sample_count  (o_sample_count)
    );

    srs_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_packet_type   (i_packet_type),
        .i_packet_length (i_packet_length),
        .i_sample_value  (i_sample_value),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_accepted      (o_accepted),
        .i_channel       (o_channel),
        .i_echo_value    (o_echo_value),
        .i_mean_value    (o_mean_value),
        .i_lowest_value  (o_lowest_value),
        .i_highest_value (o_highest_value),
        .i_sample_count  (o_sample_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_packet(input logic [7:0] ptype, input logic [8:0] plen,
                               input logic [31:0] sample);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_packet_type   <= ptype;
        i_packet_length <= plen;
        i_sample_value  <= sample;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            case ($urandom_range(3))
                0:       return srs_pkg::TYPE_TEMP;
                1:       return srs_pkg::TYPE_HUM;
                2:       return srs_pkg::TYPE_CO2;
                default: return srs_pkg::TYPE_TVOC;
            endcase
        end
        if (r < 80)
            return $urandom_range(1) ? srs_pkg::TYPE_CO2 - 8'd1 : srs_pkg::TYPE_TVOC + 8'd1;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [8:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 9'($urandom_range(srs_pkg::MIN_LENGTH - 1));
        if (r < 20)
            return $urandom_range(1) ? srs_pkg::MIN_LENGTH : 9'h1FF;
        return 9'($urandom_range(511, srs_pkg::MIN_LENGTH));
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_packet_type   = '0;
        i_packet_length = '0;
        i_sample_value  = '0;
        gap_pct         = 0;
        stall_pct       = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first samples seed min and max
        send_packet(srs_pkg::TYPE_TEMP, srs_pkg::MIN_LENGTH, 32'h7FFF_FFFF);
        send_packet(srs_pkg::TYPE_HUM, 9'h1FF, 32'h8000_0000);
        send_packet(srs_pkg::TYPE_CO2, srs_pkg::MIN_LENGTH, 32'h0);
        send_packet(srs_pkg::TYPE_TVOC, 9'd300, 32'hFFFF_FFFF);
        // short and unknown packets
        send_packet(srs_pkg::TYPE_TEMP, srs_pkg::MIN_LENGTH - 9'd1, 32'd1);
        send_packet(srs_pkg::TYPE_CO2, 9'd0, 32'h7FFF_FFFF);
        send_packet(8'h00, 9'h1FF, 32'd5);
        send_packet(8'hFF, 9'd20, 32'd5);
        send_packet(srs_pkg::TYPE_CO2 - 8'd1, 9'd20, 32'd5);
        send_packet(srs_pkg::TYPE_TVOC + 8'd1, 9'd20, 32'd5);
        // negative means truncate toward zero
        send_packet(srs_pkg::TYPE_TEMP, 9'd8, 32'h8000_0000);
        send_packet(srs_pkg::TYPE_CO2, 9'd8, 32'hFFFF_FFF9);
        send_packet(srs_pkg::TYPE_CO2, 9'd8, 32'd1);
        send_packet(srs_pkg::TYPE_HUM, 9'd8, 32'h7FFF_FFFF);
        send_packet(srs_pkg::TYPE_TVOC, 9'd8, 32'hFFFF_FFFE);
        send_packet(srs_pkg::TYPE_TVOC, 9'd8, 32'd5);
        send_packet(srs_pkg::TYPE_TEMP, 9'h1FF, 32'h7FFF_FFFF);
        send_packet(srs_pkg::TYPE_TEMP, 9'h1FF, 32'h7FFF_FFFF);
        send_packet(srs_pkg::TYPE_HUM, 9'h100, 32'h8000_0000);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 88; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 88; end
                default: begin gap_pct = 15; stall_pct = 15; end
            endcase
            repeat (133)
                send_packet(pick_type(), pick_length(), pick_sample());
            drain_results();
        end

        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
